@@ rtl/swm_pkg.sv @@
package swm_pkg;

    localparam int MAX_PATTERN_DEF = 32;
    localparam logic [7:0] STAR_BYTE = 8'd42;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_END     = 2'd3
    } cmd_t;

    typedef struct packed {
        logic clear;
        logic append;
        logic subject;
        logic finish;
    } op_t;

endpackage

@@ rtl/swm_pattern.sv @@
module swm_pattern #(
    parameter int MAX_PATTERN = swm_pkg::MAX_PATTERN_DEF,
    parameter int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swm_pkg::op_t         op,
    input  logic [7:0]           symbol,
    output logic [MAX_PATTERN:0] star_mask,
    output logic [MAX_PATTERN-1:0] lit_hit,
    output logic [LW-1:0]        length,
    output logic                 overflow
);

    logic [7:0]    store_reg [MAX_PATTERN];
    logic [LW-1:0] length_reg;
    logic [LW-1:0] length_next;
    logic          overflow_reg;
    logic          overflow_next;
    logic          full;

    assign full = (length_reg == LW'(MAX_PATTERN));

    always_comb
    begin
        length_next   = length_reg;
        overflow_next = overflow_reg;
        if (op.clear)
        begin
            length_next   = '0;
            overflow_next = 1'b0;
        end
        else if (op.append)
        begin
            if (full)
                overflow_next = 1'b1;
            else
                length_next = length_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            length_reg   <= length_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (op.append && !full && length_reg == LW'(i))
                store_reg[i] <= symbol;
        end
    end

    always_comb
    begin
        star_mask = '0;
        lit_hit   = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (LW'(i) < length_reg)
            begin
                star_mask[i] = (store_reg[i] == swm_pkg::STAR_BYTE);
                lit_hit[i]   = (store_reg[i] != swm_pkg::STAR_BYTE) &&
                               (store_reg[i] == symbol);
            end
        end
    end

    assign length   = length_reg;
    assign overflow = overflow_reg;

endmodule

@@ rtl/swm_track.sv @@
module swm_track #(
    parameter int MAX_PATTERN = swm_pkg::MAX_PATTERN_DEF,
    parameter int LW = $clog2(MAX_PATTERN + 1)
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  swm_pkg::op_t           op,
    input  logic [MAX_PATTERN:0]   star_mask,
    input  logic [MAX_PATTERN-1:0] lit_hit,
    input  logic [LW-1:0]          length,
    input  logic                   overflow,
    output logic                   hit
);

    logic [MAX_PATTERN:0] act_reg;
    logic [MAX_PATTERN:0] act_next;
    logic                 open_reg;
    logic                 open_next;
    logic [MAX_PATTERN:0] start_vec;
    logic [MAX_PATTERN:0] step_vec;

    // carry chain runs activity through each run of stars
    function automatic logic [MAX_PATTERN:0] spread(
        input logic [MAX_PATTERN:0] v,
        input logic [MAX_PATTERN:0] s
    );
        logic [MAX_PATTERN:0] m;
        logic [MAX_PATTERN:0] sum;
        m   = v & s;
        sum = m + s;
        return v | (sum ^ m ^ s);
    endfunction

    always_comb
    begin
        start_vec = open_reg ? act_reg
                             : spread((MAX_PATTERN + 1)'(1), star_mask);
        step_vec  = spread((start_vec & star_mask) |
                           {start_vec[MAX_PATTERN-1:0] & lit_hit, 1'b0},
                           star_mask);
        hit       = start_vec[length] && !overflow;

        act_next  = act_reg;
        open_next = open_reg;
        if (op.clear || op.append || op.finish)
        begin
            act_next  = '0;
            open_next = 1'b0;
        end
        else if (op.subject)
        begin
            act_next  = step_vec;
            open_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg  <= '0;
            open_reg <= 1'b0;
        end
        else
        begin
            act_reg  <= act_next;
            open_reg <= open_next;
        end
    end

endmodule

@@ rtl/star_wildcard_matcher.sv @@
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | command, symbol
// out     | out_valid | out_stall | matched, pattern_overflow
//
// One request per cycle unless stalled; an end result goes via the input and result registers.
// The active-position vector updates in one pass per request; each star ripple is one carry chain.
// Reset clears the pattern length, overflow flag, vector and both stage valids.
// An end request holds in the input stage while the result register is full and stalled.
module star_wildcard_matcher #(
    parameter int MAX_PATTERN = swm_pkg::MAX_PATTERN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [7:0] symbol,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       matched,
    output logic       pattern_overflow
);

    localparam int LW = $clog2(MAX_PATTERN + 1);

    logic                   in_valid_reg;
    swm_pkg::cmd_t          cmd_reg;
    logic [7:0]             sym_reg;
    logic                   out_valid_reg;
    logic                   matched_reg;
    logic                   overflow_reg;
    logic                   go;
    swm_pkg::op_t           op;
    logic [MAX_PATTERN:0]   star_mask;
    logic [MAX_PATTERN-1:0] lit_hit;
    logic [LW-1:0]          length;
    logic                   overflow;
    logic                   hit;

    assign go = in_valid_reg &&
                (cmd_reg != swm_pkg::CMD_END || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !go;

    always_comb
    begin
        op = '0;
        if (go)
        begin
            unique case (cmd_reg)
                swm_pkg::CMD_CLEAR:   op.clear   = 1'b1;
                swm_pkg::CMD_APPEND:  op.append  = 1'b1;
                swm_pkg::CMD_SUBJECT: op.subject = 1'b1;
                swm_pkg::CMD_END:     op.finish  = 1'b1;
                default:              op = '0;
            endcase
        end
    end

    swm_pattern #(
        .MAX_PATTERN(MAX_PATTERN),
        .LW(LW)
    ) u_pattern (
        .clk(clk),
        .rst_n(rst_n),
        .op(op),
        .symbol(sym_reg),
        .star_mask(star_mask),
        .lit_hit(lit_hit),
        .length(length),
        .overflow(overflow)
    );

    swm_track #(
        .MAX_PATTERN(MAX_PATTERN),
        .LW(LW)
    ) u_track (
        .clk(clk),
        .rst_n(rst_n),
        .op(op),
        .star_mask(star_mask),
        .lit_hit(lit_hit),
        .length(length),
        .overflow(overflow),
        .hit(hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (op.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= swm_pkg::cmd_t'(command);
            sym_reg <= symbol;
        end
        if (op.finish)
        begin
            matched_reg  <= hit;
            overflow_reg <= overflow;
        end
    end

    assign out_valid        = out_valid_reg;
    assign matched          = matched_reg;
    assign pattern_overflow = overflow_reg;

endmodule
